FILE: src/ptd_pkg.sv
package ptd_pkg;

   localparam int KEY_W        = 8;
   localparam int DATA_W       = 32;
   localparam int REQ_W        = 3;
   localparam int HALF_W       = 16;
   localparam int RESULT_LIMIT = 16;
   localparam int FIRE_W       = $clog2(RESULT_LIMIT + 1);

   // request codes
   localparam logic [REQ_W-1:0] REQ_REGISTER   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_LOGOUT     = 3'd1;
   localparam logic [REQ_W-1:0] REQ_SET_REPEAT = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SET_PERIOD = 3'd3;
   localparam logic [REQ_W-1:0] REQ_TICK       = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] repeat_cnt;
      logic [DATA_W-1:0] period;
      logic [DATA_W-1:0] last_fire;
   } entry_type;

   typedef enum logic [2:0] {
      WR_APPEND,
      WR_UPDATE,
      WR_SET_REPEAT,
      WR_SET_PERIOD,
      WR_SHIFT,
      WR_FIRE
   } wr_kind_type;

   typedef enum logic [1:0] {
      OUT_OK,
      OUT_FAIL,
      OUT_FIRE_PREV,
      OUT_TICK_END
   } out_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_TICK_END,
      ST_EMIT_OK,
      ST_EMIT_FAIL
   } state_type;

   typedef struct packed {
      logic         req_ready;
      logic         idx_clr;
      logic         idx_inc;
      logic         rd_en;
      logic         rd_next;
      logic         wr_en;
      wr_kind_type  wr_kind;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         fired_clr;
      logic         fired_inc;
      logic         out_load;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic             req_valid;
      logic [REQ_W-1:0] req_code;
      logic             key_zero;
      logic             table_full;
      logic             cnt_zero;
      logic             idx_at_end;
      logic             next_at_end;
      logic             key_match;
      logic             due;
      logic             fired_any;
      logic             fired_at_limit;
      logic             first_only;
      logic             out_busy;
   } status_type;

endpackage

FILE: src/ptd_if.sv
interface ptd_req_if;
   logic                             valid;
   logic                             ready;
   logic [ptd_pkg::REQ_W-1:0]        req_type;
   logic [ptd_pkg::KEY_W-1:0]        task_key;
   logic signed [ptd_pkg::DATA_W-1:0] repeat_count;
   logic [ptd_pkg::DATA_W-1:0]       period_ticks;
   logic [ptd_pkg::DATA_W-1:0]       tick_now;

   modport source (output valid, req_type, task_key, repeat_count, period_ticks, tick_now,
                   input ready);
   modport sink (input valid, req_type, task_key, repeat_count, period_ticks, tick_now,
                 output ready);
endinterface

interface ptd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      status_ok;
   logic                      fired;
   logic [ptd_pkg::KEY_W-1:0] fired_key;
   logic                      last;

   modport source (output valid, status_ok, fired, fired_key, last, input ready);
   modport sink (input valid, status_ok, fired, fired_key, last, output ready);
endinterface

FILE: src/ptd_ctrl.sv
module ptd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  ptd_pkg::status_type status,
   output ptd_pkg::cmd_type    cmd
);

   ptd_pkg::state_type state_ff;
   ptd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (status.req_valid) state_in = ptd_pkg::ST_DECODE;
         end
         ptd_pkg::ST_DECODE: begin
            unique case (status.req_code) inside
               ptd_pkg::REQ_TICK: begin
                  state_in = ptd_pkg::ST_SCAN_RD;
               end
               ptd_pkg::REQ_REGISTER: begin
                  if (status.key_zero || status.table_full) state_in = ptd_pkg::ST_EMIT_FAIL;
                  else if (status.cnt_zero) state_in = ptd_pkg::ST_EMIT_OK;
                  else state_in = ptd_pkg::ST_FIND_RD;
               end
               ptd_pkg::REQ_LOGOUT, ptd_pkg::REQ_SET_REPEAT, ptd_pkg::REQ_SET_PERIOD: begin
                  if (status.key_zero || status.cnt_zero) state_in = ptd_pkg::ST_EMIT_FAIL;
                  else state_in = ptd_pkg::ST_FIND_RD;
               end
               default: begin
                  state_in = ptd_pkg::ST_EMIT_FAIL;
               end
            endcase
         end
         ptd_pkg::ST_FIND_RD: begin
            state_in = ptd_pkg::ST_FIND_CHK;
         end
         ptd_pkg::ST_FIND_CHK: begin
            if (status.key_match) begin
               if (status.req_code == ptd_pkg::REQ_LOGOUT) state_in = ptd_pkg::ST_SHIFT_RD;
               else state_in = ptd_pkg::ST_EMIT_OK;
            end else if (status.next_at_end) begin
               if (status.req_code == ptd_pkg::REQ_REGISTER) state_in = ptd_pkg::ST_EMIT_OK;
               else state_in = ptd_pkg::ST_EMIT_FAIL;
            end else begin
               state_in = ptd_pkg::ST_FIND_RD;
            end
         end
         ptd_pkg::ST_SHIFT_RD: begin
            if (status.next_at_end) state_in = ptd_pkg::ST_EMIT_OK;
            else state_in = ptd_pkg::ST_SHIFT_WR;
         end
         ptd_pkg::ST_SHIFT_WR: begin
            state_in = ptd_pkg::ST_SHIFT_RD;
         end
         ptd_pkg::ST_SCAN_RD: begin
            if (status.idx_at_end) state_in = ptd_pkg::ST_TICK_END;
            else state_in = ptd_pkg::ST_SCAN_CHK;
         end
         ptd_pkg::ST_SCAN_CHK: begin
            if (!status.due) begin
               state_in = ptd_pkg::ST_SCAN_RD;
            end else if (!(status.fired_any && status.out_busy)) begin
               if (status.first_only || status.fired_at_limit) state_in = ptd_pkg::ST_TICK_END;
               else state_in = ptd_pkg::ST_SCAN_RD;
            end
         end
         ptd_pkg::ST_TICK_END, ptd_pkg::ST_EMIT_OK, ptd_pkg::ST_EMIT_FAIL: begin
            if (!status.out_busy) state_in = ptd_pkg::ST_IDLE;
         end
         default: begin
            state_in = ptd_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
         end
         ptd_pkg::ST_DECODE: begin
            cmd.idx_clr   = 1'b1;
            cmd.fired_clr = 1'b1;
            if (status.req_code == ptd_pkg::REQ_REGISTER && !status.key_zero &&
                !status.table_full && status.cnt_zero) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_kind = ptd_pkg::WR_APPEND;
               cmd.cnt_inc = 1'b1;
            end
         end
         ptd_pkg::ST_FIND_RD: begin
            cmd.rd_en = 1'b1;
         end
         ptd_pkg::ST_FIND_CHK: begin
            if (status.key_match) begin
               unique case (status.req_code) inside
                  ptd_pkg::REQ_REGISTER: begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_kind = ptd_pkg::WR_UPDATE;
                  end
                  ptd_pkg::REQ_SET_REPEAT: begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_kind = ptd_pkg::WR_SET_REPEAT;
                  end
                  ptd_pkg::REQ_SET_PERIOD: begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_kind = ptd_pkg::WR_SET_PERIOD;
                  end
                  default: begin
                     cmd.wr_en = 1'b0;
                  end
               endcase
            end else if (status.next_at_end) begin
               if (status.req_code == ptd_pkg::REQ_REGISTER) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_kind = ptd_pkg::WR_APPEND;
                  cmd.cnt_inc = 1'b1;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ptd_pkg::ST_SHIFT_RD: begin
            if (status.next_at_end) begin
               cmd.cnt_dec = 1'b1;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
            end
         end
         ptd_pkg::ST_SHIFT_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_kind = ptd_pkg::WR_SHIFT;
            cmd.idx_inc = 1'b1;
         end
         ptd_pkg::ST_SCAN_RD: begin
            cmd.rd_en = !status.idx_at_end;
         end
         ptd_pkg::ST_SCAN_CHK: begin
            if (!status.due) begin
               cmd.idx_inc = 1'b1;
            end else if (!(status.fired_any && status.out_busy)) begin
               cmd.wr_en     = 1'b1;
               cmd.wr_kind   = ptd_pkg::WR_FIRE;
               cmd.fired_inc = 1'b1;
               cmd.idx_inc   = 1'b1;
               cmd.out_load  = status.fired_any;
               cmd.out_kind  = ptd_pkg::OUT_FIRE_PREV;
            end
         end
         ptd_pkg::ST_TICK_END: begin
            cmd.out_load = !status.out_busy;
            cmd.out_kind = ptd_pkg::OUT_TICK_END;
         end
         ptd_pkg::ST_EMIT_OK: begin
            cmd.out_load = !status.out_busy;
            cmd.out_kind = ptd_pkg::OUT_OK;
         end
         ptd_pkg::ST_EMIT_FAIL: begin
            cmd.out_load = !status.out_busy;
            cmd.out_kind = ptd_pkg::OUT_FAIL;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: src/ptd_datapath.sv
module ptd_datapath #(
   parameter int MAX_TASKS = 16
) (
   input  logic                clock,
   input  logic                reset,
   ptd_req_if.sink             req_chan,
   ptd_rsp_if.source           rsp_chan,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  ptd_pkg::cmd_type    cmd,
   output ptd_pkg::status_type status
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   // latched request
   logic [ptd_pkg::REQ_W-1:0]  req_code_ff;
   logic [ptd_pkg::KEY_W-1:0]  req_key_ff;
   logic [ptd_pkg::DATA_W-1:0] req_rep_ff;
   logic [ptd_pkg::DATA_W-1:0] req_per_ff;
   logic [ptd_pkg::DATA_W-1:0] req_now_ff;

   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           idx_ff;
   logic [ptd_pkg::FIRE_W-1:0] fired_ff;
   logic [ptd_pkg::KEY_W-1:0]  held_key_ff;
   logic                       first_only_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_ok_ff;
   logic                       rsp_fired_ff;
   logic [ptd_pkg::KEY_W-1:0]  rsp_key_ff;
   logic                       rsp_last_ff;

   ptd_pkg::entry_type         table_mem [MAX_TASKS];
   ptd_pkg::entry_type         rd_data_ff;
   ptd_pkg::entry_type         wr_data;
   logic [IDX_W-1:0]           rd_addr;
   logic [IDX_W-1:0]           wr_addr;
   logic [CNT_W-1:0]           idx_plus;
   logic [ptd_pkg::DATA_W-1:0] elapsed;
   logic [ptd_pkg::DATA_W-1:0] rep_sext;
   logic [ptd_pkg::DATA_W-1:0] rep_fired;

   assign idx_plus = idx_ff + CNT_W'(1);
   assign rd_addr  = cmd.rd_next ? idx_plus[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_addr  = (cmd.wr_kind == ptd_pkg::WR_APPEND) ? cnt_ff[IDX_W-1:0]
                                                         : idx_ff[IDX_W-1:0];
   assign elapsed  = req_now_ff - rd_data_ff.last_fire;
   assign rep_sext = {{(ptd_pkg::DATA_W - ptd_pkg::HALF_W){req_rep_ff[ptd_pkg::HALF_W-1]}},
                      req_rep_ff[ptd_pkg::HALF_W-1:0]};
   assign rep_fired = rd_data_ff.repeat_cnt[ptd_pkg::DATA_W-1] ? rd_data_ff.repeat_cnt
                      : rd_data_ff.repeat_cnt - ptd_pkg::DATA_W'(1);

   always_comb begin
      wr_data = rd_data_ff;
      case (cmd.wr_kind)
         ptd_pkg::WR_APPEND: begin
            wr_data.key        = req_key_ff;
            wr_data.repeat_cnt = req_rep_ff;
            wr_data.period     = req_per_ff;
            wr_data.last_fire  = '0;
         end
         ptd_pkg::WR_UPDATE: begin
            wr_data.repeat_cnt = req_rep_ff;
            wr_data.period     = req_per_ff;
         end
         ptd_pkg::WR_SET_REPEAT: wr_data.repeat_cnt = rep_sext;
         ptd_pkg::WR_SET_PERIOD: wr_data.period = req_per_ff;
         ptd_pkg::WR_FIRE: begin
            wr_data.repeat_cnt = rep_fired;
            wr_data.last_fire  = req_now_ff;
         end
         default: wr_data = rd_data_ff;
      endcase
   end

   // task table
   always_ff @(posedge clock) begin
      if (cmd.wr_en) table_mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.req_ready && req_chan.valid) begin
         req_code_ff <= req_chan.req_type;
         req_key_ff  <= req_chan.task_key;
         req_rep_ff  <= req_chan.repeat_count;
         req_per_ff  <= req_chan.period_ticks;
         req_now_ff  <= req_chan.tick_now;
      end
      if (cmd.fired_inc) held_key_ff <= rd_data_ff.key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         idx_ff        <= '0;
         fired_ff      <= '0;
         first_only_ff <= 1'b0;
      end else begin
         if (cmd.cnt_inc) cnt_ff <= cnt_ff + CNT_W'(1);
         else if (cmd.cnt_dec) cnt_ff <= cnt_ff - CNT_W'(1);
         if (cmd.idx_clr) idx_ff <= '0;
         else if (cmd.idx_inc) idx_ff <= idx_plus;
         if (cmd.fired_clr) fired_ff <= '0;
         else if (cmd.fired_inc) fired_ff <= fired_ff + ptd_pkg::FIRE_W'(1);
         if (csr_wr_en) first_only_ff <= csr_wr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (cmd.out_kind)
            ptd_pkg::OUT_OK: begin
               rsp_ok_ff    <= 1'b1;
               rsp_fired_ff <= 1'b0;
               rsp_key_ff   <= '0;
               rsp_last_ff  <= 1'b1;
            end
            ptd_pkg::OUT_FAIL: begin
               rsp_ok_ff    <= 1'b0;
               rsp_fired_ff <= 1'b0;
               rsp_key_ff   <= '0;
               rsp_last_ff  <= 1'b1;
            end
            ptd_pkg::OUT_FIRE_PREV: begin
               rsp_ok_ff    <= 1'b1;
               rsp_fired_ff <= 1'b1;
               rsp_key_ff   <= held_key_ff;
               rsp_last_ff  <= 1'b0;
            end
            default: begin
               rsp_ok_ff    <= 1'b1;
               rsp_fired_ff <= status.fired_any;
               rsp_key_ff   <= status.fired_any ? held_key_ff : '0;
               rsp_last_ff  <= 1'b1;
            end
         endcase
      end
   end

   // no request is taken while reset is held
   assign req_chan.ready     = cmd.req_ready && !reset;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status_ok = rsp_ok_ff;
   assign rsp_chan.fired     = rsp_fired_ff;
   assign rsp_chan.fired_key = rsp_key_ff;
   assign rsp_chan.last      = rsp_last_ff;

   always_comb begin
      status.req_valid      = req_chan.valid;
      status.req_code       = req_code_ff;
      status.key_zero       = (req_key_ff == '0);
      status.table_full     = (cnt_ff == CNT_W'(MAX_TASKS));
      status.cnt_zero       = (cnt_ff == '0);
      status.idx_at_end     = (idx_ff == cnt_ff);
      status.next_at_end    = ({1'b0, idx_ff} + (CNT_W + 1)'(1)) >= {1'b0, cnt_ff};
      status.key_match      = (rd_data_ff.key == req_key_ff);
      status.due            = (rd_data_ff.repeat_cnt != '0) && (rd_data_ff.key != '0) &&
                              (elapsed >= rd_data_ff.period);
      status.fired_any      = (fired_ff != '0);
      status.fired_at_limit = (fired_ff == ptd_pkg::FIRE_W'(ptd_pkg::RESULT_LIMIT - 1));
      status.first_only     = first_only_ff;
      status.out_busy       = rsp_valid_ff && !rsp_chan.ready;
   end

endmodule

FILE: src/periodic_task_dispatcher.sv
// periodic task dispatcher: a packed table of up to MAX_TASKS periodic tasks
// req_chan carries one request (register, logout, set repeat, set period, tick);
// rsp_chan returns results, the final one of each request flagged by last
// non-tick requests give exactly one result; a tick gives one result per fired
// task in table order, or a single empty result when nothing is due
// csr_wr_en / csr_wr_data write first_only (a tick then fires at most one task)
// a request is taken only while the controller is idle; the table
// lives in a single-port-read memory, so lookups, logout shifts and tick scans
// walk it one entry at a time, each entry taking a read state and then a
// check state (lookups and tick scans) or a write state (logout shifts);
// the final result is then loaded into the output register
// the result sits in an output register, so a new request can be taken while
// the previous result still waits on rsp_chan.ready
// a stalled receiver holds a tick scan at its next firing until the slot frees
// reset clears the task count, the first_only register and the control state;
// table contents are left as they are and never read before being written
module periodic_task_dispatcher #(
   parameter int MAX_TASKS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ptd_req_if.sink   req_chan,
   ptd_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   // command and status between sequencer and table datapath
   ptd_pkg::cmd_type    cmd;
   ptd_pkg::status_type status;

   // sequencer: decode, lookup, shift, scan and result emission
   ptd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // table memory, counters, request latch and output register
   ptd_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
